FILE: rtl/h_bridge_dual_pwm_generator_top_macros.svh
// assertion macros for the h-bridge pwm generator
`ifndef H_BRIDGE_DUAL_PWM_GENERATOR_TOP_MACROS_SVH
`define H_BRIDGE_DUAL_PWM_GENERATOR_TOP_MACROS_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define HBPWM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define HBPWM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/hbpwm_pkg.sv
// shared types and constants of the h-bridge pwm generator
package hbpwm_pkg;

   localparam int FREQ_BITS  = 17;
   localparam int DUTY_BITS  = 7;
   localparam int SPEED_BITS = 8;
   localparam int MODE_BITS  = 2;
   localparam int REG_BITS   = 2;

   localparam logic [FREQ_BITS-1:0] BASE_RESET = 17'd20000;
   localparam logic [FREQ_BITS-1:0] PWM_RESET  = 17'd1000;
   // 2 * (20000 / 1000)
   localparam int RESET_PERIOD = 40;

   localparam logic [DUTY_BITS-1:0]         FULL_DUTY = 7'd100;
   localparam logic signed [SPEED_BITS-1:0] SPEED_MAX = 8'sd100;
   localparam logic signed [SPEED_BITS-1:0] SPEED_MIN = -8'sd100;

   typedef logic [MODE_BITS-1:0] mode_type;
   localparam mode_type MODE_TICK  = 2'd0;
   localparam mode_type MODE_SPEED = 2'd1;
   localparam mode_type MODE_BRAKE = 2'd2;

   typedef logic [REG_BITS-1:0] reg_index_type;
   localparam reg_index_type REG_BASE   = 2'd0;
   localparam reg_index_type REG_PWM    = 2'd1;
   localparam reg_index_type REG_ENABLE = 2'd2;

   typedef struct packed {
      logic busy;
      logic refresh;
   } period_status_type;

   typedef struct packed {
      logic leg_b;
      logic leg_a;
   } legs_type;

endpackage

FILE: rtl/hbpwm_period.sv
// period unit: clamps the pwm rate and divides base by it one bit a cycle
module hbpwm_period #(
   parameter int COUNT_BITS = 18
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [hbpwm_pkg::FREQ_BITS-1:0]       base_frequency,
   input  logic [hbpwm_pkg::FREQ_BITS-1:0]       pwm_frequency,
   output logic [COUNT_BITS-1:0]                 period,
   output hbpwm_pkg::period_status_type          status
);

   localparam int FB         = hbpwm_pkg::FREQ_BITS;
   localparam int WIDE_BITS  = (COUNT_BITS > FB + 1) ? COUNT_BITS : FB + 1;
   localparam int STEP_BITS  = $clog2(FB);
   localparam logic [WIDE_BITS-1:0] LIMIT = WIDE_BITS'((64'd1 << COUNT_BITS) - 64'd2);
   localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(FB - 1);

   typedef enum logic [1:0] {ST_IDLE, ST_DIVIDE, ST_LOAD, ST_REFRESH} state_type;

   state_type              state_ff,     state_in;
   logic [FB-1:0]          dividend_ff,  dividend_in;
   logic [FB-1:0]          divisor_ff,   divisor_in;
   logic [FB-1:0]          remainder_ff, remainder_in;
   logic [STEP_BITS-1:0]   step_ff,      step_in;
   logic [COUNT_BITS-1:0]  period_ff,    period_in;

   logic [FB-1:0]          clamped;
   logic [FB:0]            partial;
   logic [FB:0]            reduced;
   logic                   fits;
   logic [WIDE_BITS-1:0]   doubled;

   always_comb begin
      // rate above base falls to base, zero rate rises to one
      clamped = (pwm_frequency > base_frequency) ? base_frequency : pwm_frequency;
      if (clamped == '0) begin
         clamped = FB'(1);
      end
      partial = {remainder_ff, dividend_ff[FB-1]};
      reduced = partial - {1'b0, divisor_ff};
      fits    = (partial >= {1'b0, divisor_ff});
      doubled = WIDE_BITS'({dividend_ff, 1'b0});

      state_in     = state_ff;
      dividend_in  = dividend_ff;
      divisor_in   = divisor_ff;
      remainder_in = remainder_ff;
      step_in      = step_ff;
      period_in    = period_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               dividend_in  = base_frequency;
               divisor_in   = clamped;
               remainder_in = '0;
               step_in      = '0;
               state_in     = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            // restoring step, quotient bits shift in behind the dividend
            remainder_in = fits ? reduced[FB-1:0] : partial[FB-1:0];
            dividend_in  = {dividend_ff[FB-2:0], fits};
            step_in      = step_ff + STEP_BITS'(1);
            if (step_ff == LAST_STEP) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            period_in = COUNT_BITS'((doubled > LIMIT) ? LIMIT : doubled);
            state_in  = ST_REFRESH;
         end
         ST_REFRESH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         period_ff <= COUNT_BITS'(hbpwm_pkg::RESET_PERIOD);
      end else begin
         state_ff  <= state_in;
         period_ff <= period_in;
      end
      dividend_ff  <= dividend_in;
      divisor_ff   <= divisor_in;
      remainder_ff <= remainder_in;
      step_ff      <= step_in;
   end

   assign period         = period_ff;
   assign status.busy    = (state_ff != ST_IDLE);
   assign status.refresh = (state_ff == ST_REFRESH);

endmodule

FILE: rtl/hbpwm_legs.sv
// leg stage: duties, threshold products, tick counter and held pin levels
module hbpwm_legs #(
   parameter int COUNT_BITS = 18
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       fire,
   input  hbpwm_pkg::mode_type                        mode,
   input  logic signed [hbpwm_pkg::SPEED_BITS-1:0]    speed,
   input  logic [COUNT_BITS-1:0]                      period,
   input  logic                                       refresh,
   input  logic                                       clear_forward,
   output hbpwm_pkg::legs_type                        levels
);

   localparam int DB        = hbpwm_pkg::DUTY_BITS;
   localparam int SB        = hbpwm_pkg::SPEED_BITS;
   localparam int PROD_BITS = COUNT_BITS + DB;

   logic [DB-1:0]          fwd_duty_ff,  fwd_duty_in;
   logic [DB-1:0]          rev_duty_ff,  rev_duty_in;
   logic [PROD_BITS-1:0]   prod_a_ff,    prod_a_in;
   logic [PROD_BITS-1:0]   prod_b_ff,    prod_b_in;
   logic [COUNT_BITS-1:0]  count_ff,     count_in;
   logic [PROD_BITS-1:0]   count100_ff,  count100_in;
   hbpwm_pkg::legs_type    held_ff,      held_in;

   logic signed [SB-1:0]   clamped;
   logic [SB-1:0]          negated;
   logic [DB-1:0]          fwd_new;
   logic [DB-1:0]          rev_new;
   logic [DB-1:0]          mul_a_duty;
   logic [DB-1:0]          mul_b_duty;
   logic [PROD_BITS-1:0]   mul_a;
   logic [PROD_BITS-1:0]   mul_b;

   always_comb begin
      clamped = speed;
      if (speed < hbpwm_pkg::SPEED_MIN) begin
         clamped = hbpwm_pkg::SPEED_MIN;
      end else if (speed > hbpwm_pkg::SPEED_MAX) begin
         clamped = hbpwm_pkg::SPEED_MAX;
      end
      negated = SB'(-clamped);
      fwd_new = clamped[SB-1] ? '0 : clamped[DB-1:0];
      rev_new = clamped[SB-1] ? negated[DB-1:0] : '0;

      // two multipliers, shared between duty updates and the refresh after a new period
      if (refresh) begin
         mul_a_duty = fwd_duty_ff;
         mul_b_duty = rev_duty_ff;
      end else if (mode == hbpwm_pkg::MODE_BRAKE) begin
         mul_a_duty = hbpwm_pkg::FULL_DUTY;
         mul_b_duty = hbpwm_pkg::FULL_DUTY;
      end else begin
         mul_a_duty = fwd_new;
         mul_b_duty = rev_new;
      end
      mul_a = PROD_BITS'(period) * PROD_BITS'(mul_a_duty);
      mul_b = PROD_BITS'(period) * PROD_BITS'(mul_b_duty);

      fwd_duty_in = fwd_duty_ff;
      rev_duty_in = rev_duty_ff;
      prod_a_in   = prod_a_ff;
      prod_b_in   = prod_b_ff;
      count_in    = count_ff;
      count100_in = count100_ff;
      held_in     = held_ff;

      if (refresh) begin
         prod_a_in = mul_a;
         prod_b_in = mul_b;
      end else if (fire) begin
         case (mode)
            hbpwm_pkg::MODE_TICK: begin
               if (count_ff <= period) begin
                  // floor(period * duty / 100) >= count  <=>  period * duty >= 100 * count
                  held_in.leg_a = !(prod_a_ff >= count100_ff);
                  held_in.leg_b = !(prod_b_ff >= count100_ff);
                  count_in      = count_ff + COUNT_BITS'(1);
                  count100_in   = count100_ff + PROD_BITS'(hbpwm_pkg::FULL_DUTY);
               end else begin
                  count_in    = '0;
                  count100_in = '0;
               end
            end
            hbpwm_pkg::MODE_SPEED: begin
               fwd_duty_in = fwd_new;
               rev_duty_in = rev_new;
               prod_a_in   = mul_a;
               prod_b_in   = mul_b;
            end
            hbpwm_pkg::MODE_BRAKE: begin
               fwd_duty_in = hbpwm_pkg::FULL_DUTY;
               rev_duty_in = hbpwm_pkg::FULL_DUTY;
               prod_a_in   = mul_a;
               prod_b_in   = mul_b;
            end
            default: begin
            end
         endcase
      end

      // product follows in the refresh after the period recompute
      if (clear_forward) begin
         fwd_duty_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_duty_ff <= '0;
         rev_duty_ff <= '0;
         prod_a_ff   <= '0;
         prod_b_ff   <= '0;
         count_ff    <= '0;
         count100_ff <= '0;
         held_ff     <= '0;
      end else begin
         fwd_duty_ff <= fwd_duty_in;
         rev_duty_ff <= rev_duty_in;
         prod_a_ff   <= prod_a_in;
         prod_b_ff   <= prod_b_in;
         count_ff    <= count_in;
         count100_ff <= count100_in;
         held_ff     <= held_in;
      end
   end

   assign levels = held_in;

endmodule

FILE: rtl/h_bridge_dual_pwm_generator_top.sv
// top level of the two-leg h-bridge pwm generator
//
//  channel | ports            | direction | payload
//  --------+------------------+-----------+---------------------------------------------
//  req     | req_t*           | in        | tuser: mode; tdata: speed
//  rsp     | rsp_t*           | out       | tdata: leg_a_level, leg_b_level, inhibit_level
//  csr     | csr_*            | in        | csr_index: register, csr_data: value
//
// one transaction per clock while the result side is ready and no csr write or period recompute
// is pending; a request goes through the input register, then leg logic into the result register
// a write to base or pwm frequency runs the period divider (17 quotient bits, a load and a
// product refresh); no request is taken while it is busy
// reset is synchronous: the registers that have reset values return to them, period 40 ticks
// a stalled result holds the input register, which then holds the request side

`include "h_bridge_dual_pwm_generator_top_macros.svh"

module h_bridge_dual_pwm_generator_top #(
   parameter int COUNT_BITS = 18
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,   // [7:0] speed
   input  logic [1:0]                          req_tuser,   // [1:0] mode

   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [7:0]                          rsp_tdata,   // [0] leg_a_level, [1] leg_b_level,
                                                            // [2] inhibit_level

   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [hbpwm_pkg::REG_BITS-1:0]      csr_index,
   input  logic [hbpwm_pkg::FREQ_BITS-1:0]     csr_data
);

   localparam int FB = hbpwm_pkg::FREQ_BITS;

   // configuration registers
   logic [FB-1:0]                          base_ff,   base_in;
   logic [FB-1:0]                          pwm_ff,    pwm_in;
   logic                                   enable_ff, enable_in;

   // input register
   logic                                   in_valid_ff, in_valid_in;
   hbpwm_pkg::mode_type                    mode_ff;
   logic signed [hbpwm_pkg::SPEED_BITS-1:0] speed_ff;

   // result register
   logic                                   rsp_valid_ff, rsp_valid_in;
   logic [2:0]                             rsp_data_ff,  rsp_data_in;

   logic                                   csr_fire;
   logic                                   req_fire;
   logic                                   advance;
   logic                                   period_start;
   logic                                   clear_forward;
   logic [COUNT_BITS-1:0]                  period;
   hbpwm_pkg::period_status_type           period_status;
   hbpwm_pkg::legs_type                    levels;

   assign csr_ready = !period_status.busy;
   assign csr_fire  = csr_valid && csr_ready;

   // a pending csr write goes ahead of request traffic
   assign advance    = in_valid_ff && !period_status.busy && !csr_valid &&
                       (!rsp_valid_ff || rsp_tready);
   assign req_tready = !period_status.busy && !csr_valid && (!in_valid_ff || advance);
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      base_in   = base_ff;
      pwm_in    = pwm_ff;
      enable_in = enable_ff;
      if (csr_fire) begin
         unique case (csr_index)
            hbpwm_pkg::REG_BASE:   base_in   = csr_data;
            hbpwm_pkg::REG_PWM:    pwm_in    = csr_data;
            hbpwm_pkg::REG_ENABLE: enable_in = csr_data[0];
            default: begin
            end
         endcase
      end
   end

   // both frequency registers retrigger the period divider
   assign period_start  = csr_fire && (csr_index == hbpwm_pkg::REG_BASE ||
                                       csr_index == hbpwm_pkg::REG_PWM);
   assign clear_forward = csr_fire && (csr_index == hbpwm_pkg::REG_PWM);

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {enable_ff, levels.leg_b, levels.leg_a};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= hbpwm_pkg::BASE_RESET;
         pwm_ff       <= hbpwm_pkg::PWM_RESET;
         enable_ff    <= 1'b0;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         base_ff      <= base_in;
         pwm_ff       <= pwm_in;
         enable_ff    <= enable_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_fire) begin
         mode_ff  <= req_tuser;
         speed_ff <= req_tdata;
      end
      rsp_data_ff <= rsp_data_in;
   end

   // period divider fed with the register values being written
   hbpwm_period #(
      .COUNT_BITS (COUNT_BITS)
   ) u_period (
      .clock          (clock),
      .reset          (reset),
      .start          (period_start),
      .base_frequency (base_in),
      .pwm_frequency  (pwm_in),
      .period         (period),
      .status         (period_status)
   );

   // duties, counter and pin levels for the item in the input register
   hbpwm_legs #(
      .COUNT_BITS (COUNT_BITS)
   ) u_legs (
      .clock         (clock),
      .reset         (reset),
      .fire          (advance),
      .mode          (mode_ff),
      .speed         (speed_ff),
      .period        (period),
      .refresh       (period_status.refresh),
      .clear_forward (clear_forward),
      .levels        (levels)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b00000, rsp_data_ff};

   // no request enters or moves on while the period is being recomputed
   `HBPWM_ASSERT_NOW(a_busy_blocks_req, period_status.busy, !req_tready && !advance, "request taken while period busy")
   // a frequency write starts the divider on the next cycle
   `HBPWM_ASSERT_NEXT(a_freq_write_busy, period_start, period_status.busy, "frequency write did not start divider")
   // a request held back by a stalled result is not dropped
   `HBPWM_ASSERT_NEXT(a_held_item_kept, in_valid_ff && !advance, in_valid_ff, "held request lost")

endmodule

FILE: bench/h_bridge_dual_pwm_generator_top_tb.sv
// self-checking testbench for the two-leg h-bridge pwm generator
`timescale 1ns / 100ps

module h_bridge_dual_pwm_generator_top_tb;

   localparam int COUNT_BITS = 18;
   localparam int FB = hbpwm_pkg::FREQ_BITS;
   localparam int DB = hbpwm_pkg::DUTY_BITS;
   localparam int SB = hbpwm_pkg::SPEED_BITS;
   localparam logic [COUNT_BITS:0] PERIOD_LIMIT = (COUNT_BITS + 1)'((1 << COUNT_BITS) - 2);
   localparam hbpwm_pkg::mode_type MODE_UNUSED = 2'd3;
   localparam int PHASE_COUNT = 12;
   localparam int PHASE_ITEMS = 120;
   localparam int LONG_STALL_CYCLES = 200;
   localparam int DRAIN_CYCLES = 4;

   typedef struct packed {
      hbpwm_pkg::mode_type mode;
      logic [7:0]          speed;
   } bridge_cmd_type;

   typedef struct packed {
      logic inhibit;
      logic leg_b;
      logic leg_a;
   } pin_levels_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [7:0]                     req_tdata = '0;
   logic [1:0]                     req_tuser = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [7:0]                     rsp_tdata;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [hbpwm_pkg::REG_BITS-1:0] csr_index = '0;
   logic [FB-1:0]                  csr_data = '0;

   h_bridge_dual_pwm_generator_top #(
      .COUNT_BITS (COUNT_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // commands waiting to be driven, pin levels waiting to come back
   bridge_cmd_type cmd_q[$];
   pin_levels_type pin_levels_q[$];

   int send_idle_pct = 36;
   int recv_idle_pct = 85;
   int cmd_count = 0;
   int stall_at = -1;
   int stall_left = 0;
   bit long_stall_done = 1'b0;
   int mismatch_count = 0;
   int setting_count = 0;

   // shadow of the bridge state
   logic [FB-1:0]         pwm_base;
   logic [FB-1:0]         pwm_rate;
   logic                  pwm_enable;
   logic [COUNT_BITS-1:0] pwm_count;
   logic [COUNT_BITS-1:0] pwm_period;
   logic [DB-1:0]         fwd_duty;
   logic [DB-1:0]         rev_duty;
   logic                  leg_a_pin;
   logic                  leg_b_pin;

   function automatic logic [COUNT_BITS-1:0] period_of(logic [FB-1:0] base,
                                                       logic [FB-1:0] rate);
      logic [FB-1:0]       f;
      logic [COUNT_BITS:0] p;
      f = rate;
      if (f > base) f = base;
      if (f == '0) f = FB'(1);
      p = (COUNT_BITS + 1)'(base / f) << 1;
      // saturate so the counter plus one still fits
      if (p > PERIOD_LIMIT) p = PERIOD_LIMIT;
      return p[COUNT_BITS-1:0];
   endfunction

   function automatic logic leg_pin(logic [DB-1:0] duty);
      longint unsigned threshold;
      threshold = (longint'(pwm_period) * longint'(duty)) / longint'(hbpwm_pkg::FULL_DUTY);
      return (threshold >= longint'(pwm_count)) ? 1'b0 : 1'b1;
   endfunction

   task automatic bridge_reset();
      pwm_base   = hbpwm_pkg::BASE_RESET;
      pwm_rate   = hbpwm_pkg::PWM_RESET;
      pwm_enable = 1'b0;
      pwm_count  = '0;
      fwd_duty   = '0;
      rev_duty   = '0;
      leg_a_pin  = 1'b0;
      leg_b_pin  = 1'b0;
      pwm_period = period_of(pwm_base, pwm_rate);
   endtask

   task automatic bridge_write(hbpwm_pkg::reg_index_type idx, logic [FB-1:0] value);
      case (idx)
         hbpwm_pkg::REG_BASE: begin
            pwm_base   = value;
            pwm_period = period_of(pwm_base, pwm_rate);
         end
         hbpwm_pkg::REG_PWM: begin
            pwm_rate   = value;
            pwm_period = period_of(pwm_base, pwm_rate);
            fwd_duty   = '0;
         end
         hbpwm_pkg::REG_ENABLE: pwm_enable = value[0];
         default: ;
      endcase
   endtask

   // advance the shadow by one command and queue the pin levels it yields
   task automatic bridge_step(bridge_cmd_type cmd);
      logic signed [SB-1:0] s;
      s = cmd.speed;
      case (cmd.mode)
         hbpwm_pkg::MODE_TICK: begin
            if (pwm_count <= pwm_period) begin
               leg_a_pin = leg_pin(fwd_duty);
               leg_b_pin = leg_pin(rev_duty);
               pwm_count = pwm_count + 1'b1;
            end else begin
               // end of period: count restarts, pins hold
               pwm_count = '0;
            end
         end
         hbpwm_pkg::MODE_SPEED: begin
            if (s < hbpwm_pkg::SPEED_MIN) s = hbpwm_pkg::SPEED_MIN;
            if (s > hbpwm_pkg::SPEED_MAX) s = hbpwm_pkg::SPEED_MAX;
            if (s >= 0) begin
               fwd_duty = s[DB-1:0];
               rev_duty = '0;
            end else begin
               fwd_duty = '0;
               rev_duty = DB'(-s);
            end
         end
         hbpwm_pkg::MODE_BRAKE: begin
            fwd_duty = hbpwm_pkg::FULL_DUTY;
            rev_duty = hbpwm_pkg::FULL_DUTY;
         end
         default: ;
      endcase
      pin_levels_q.push_back('{inhibit: pwm_enable, leg_b: leg_b_pin, leg_a: leg_a_pin});
   endtask

   task automatic report_mismatch(string what);
      $display("MISMATCH @%0t: %s", $time, what);
      mismatch_count++;
   endtask

   // request driver
   always @(posedge clock) begin
      bridge_cmd_type cmd;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            bridge_step('{mode: req_tuser, speed: req_tdata});
            cmd_count <= cmd_count + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (cmd_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               cmd = cmd_q.pop_front();
               req_tuser  <= cmd.mode;
               req_tdata  <= cmd.speed;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result backpressure, with one long hold-off while requests keep coming
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!long_stall_done && cmd_count == stall_at) begin
         rsp_tready      <= 1'b0;
         stall_left      <= LONG_STALL_CYCLES;
         long_stall_done <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // result monitor
   always @(posedge clock) begin
      pin_levels_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pin_levels_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result tdata=%02h", rsp_tdata));
         end else begin
            want = pin_levels_q.pop_front();
            if (rsp_tdata[0] !== want.leg_a)
               report_mismatch($sformatf("leg_a_level %b, want %b", rsp_tdata[0], want.leg_a));
            if (rsp_tdata[1] !== want.leg_b)
               report_mismatch($sformatf("leg_b_level %b, want %b", rsp_tdata[1], want.leg_b));
            if (rsp_tdata[2] !== want.inhibit)
               report_mismatch($sformatf("inhibit_level %b, want %b", rsp_tdata[2],
                                         want.inhibit));
         end
      end
   end

   task automatic push_cmd(hbpwm_pkg::mode_type mode, logic [7:0] speed);
      cmd_q.push_back('{mode: mode, speed: speed});
   endtask

   task automatic push_random_cmds(int n);
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 70)      push_cmd(hbpwm_pkg::MODE_TICK, 8'($urandom_range(0, 255)));
         else if (r < 88) push_cmd(hbpwm_pkg::MODE_SPEED, 8'($urandom_range(0, 255)));
         else if (r < 96) push_cmd(hbpwm_pkg::MODE_BRAKE, 8'($urandom_range(0, 255)));
         else             push_cmd(MODE_UNUSED, 8'($urandom_range(0, 255)));
      end
   endtask

   // hold the sender until every result is back, then let the block settle
   task automatic wait_idle();
      while (cmd_q.size() != 0 || req_tvalid || pin_levels_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(hbpwm_pkg::reg_index_type idx, logic [FB-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      bridge_write(idx, value);
      csr_valid <= 1'b0;
   endtask

   task automatic apply_setting(int phase);
      logic [FB-1:0] base;
      logic [FB-1:0] rate;
      bit            base_only;
      base      = FB'($urandom_range(0, 64));
      rate      = FB'($urandom_range(0, 80));
      base_only = $urandom_range(0, 2) == 0;
      case (phase)
         0: begin base = FB'(0);      base_only = 1'b1; end    // zero base, period zero
         1: begin base = FB'(1);      rate = FB'(0);      base_only = 1'b0; end
         2: begin base = FB'(10);     rate = FB'(3);      base_only = 1'b0; end
         3: begin base = FB'(131071); rate = FB'(1);      base_only = 1'b0; end // widest period
         4: begin base = FB'(100000); rate = FB'(100000); base_only = 1'b0; end
         5: begin base = FB'(50);     rate = FB'(131071); base_only = 1'b0; end // rate clamped
         6: begin base = FB'($urandom_range(0, 40)); base_only = 1'b1; end
         default: ;
      endcase
      csr_write(hbpwm_pkg::REG_ENABLE, FB'((phase == 2) ? 0 : (phase < 2 || phase == 3) ? 1 :
                                           $urandom_range(0, 1)));
      if (!base_only) csr_write(hbpwm_pkg::REG_PWM, rate);
      csr_write(hbpwm_pkg::REG_BASE, base);
      setting_count++;
   endtask

   initial begin
      bridge_reset();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: clamps, every mode, unused mode, all data bits, reset setting
      push_cmd(hbpwm_pkg::MODE_TICK, 8'h00);
      push_cmd(hbpwm_pkg::MODE_SPEED, 8'h7f);
      push_cmd(hbpwm_pkg::MODE_TICK, 8'hff);
      push_cmd(hbpwm_pkg::MODE_TICK, 8'h55);
      push_cmd(hbpwm_pkg::MODE_SPEED, 8'h80);
      push_cmd(hbpwm_pkg::MODE_TICK, 8'haa);
      push_cmd(hbpwm_pkg::MODE_TICK, 8'h00);
      push_cmd(hbpwm_pkg::MODE_SPEED, 8'h9c);
      push_cmd(hbpwm_pkg::MODE_SPEED, 8'h64);
      push_cmd(hbpwm_pkg::MODE_SPEED, 8'h00);
      push_cmd(hbpwm_pkg::MODE_TICK, 8'h00);
      push_cmd(hbpwm_pkg::MODE_SPEED, 8'hff);
      push_cmd(hbpwm_pkg::MODE_TICK, 8'h00);
      push_cmd(hbpwm_pkg::MODE_SPEED, 8'h01);
      push_cmd(hbpwm_pkg::MODE_TICK, 8'h00);
      push_cmd(hbpwm_pkg::MODE_BRAKE, 8'h33);
      push_cmd(hbpwm_pkg::MODE_TICK, 8'h00);
      push_cmd(hbpwm_pkg::MODE_TICK, 8'h00);
      push_cmd(MODE_UNUSED, 8'hff);
      push_cmd(MODE_UNUSED, 8'h00);
      push_cmd(hbpwm_pkg::MODE_TICK, 8'h80);
      // leave forward duty set so a base-only write shows it is kept
      push_cmd(hbpwm_pkg::MODE_SPEED, 8'h3c);
      push_cmd(hbpwm_pkg::MODE_TICK, 8'h7f);
      wait_idle();

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase < 4) begin
            send_idle_pct = 36;
            recv_idle_pct = 85;
         end else if (phase < 8) begin
            send_idle_pct = 85;
            recv_idle_pct = 36;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         apply_setting(phase);
         if (phase == 9) stall_at = cmd_count + 30;
         push_random_cmds(PHASE_ITEMS);
         wait_idle();
      end

      $display("ran %0d commands across %0d register settings (period zero to widest,",
               cmd_count, setting_count);
      $display("rate clamps, unused mode, a %0d-cycle result stall)", LONG_STALL_CYCLES);
      if (mismatch_count == 0 && pin_levels_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
